>>> src/adjacent_line_dedup_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the adjacent line filter.
// Both macros sample on aclk and are disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef ADJACENT_LINE_DEDUP_TOP_DEFINES_SVH
`define ADJACENT_LINE_DEDUP_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ADL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/adl_pkg.sv
// ---------------------------------------------------------------------------
// adl_pkg
// Types, constants and helpers shared by the adjacent line filter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package adl_pkg;

    localparam int LINE_BYTES = 4096;
    localparam int COUNT_BITS = 32;
    localparam int ADDR_W     = $clog2(LINE_BYTES);
    localparam int LEN_W      = ADDR_W + 1;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_LSB = 2;
    localparam int REG_IDX_W  = CFG_ADDR_W - REG_IDX_LSB;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FOLD_CASE      = 3'd0,
        REG_FIELDS_TO_SKIP = 3'd1,
        REG_CHARS_TO_SKIP  = 3'd2,
        REG_ONLY_REPEATED  = 3'd3,
        REG_ONLY_UNIQUE    = 3'd4,
        REG_ALL_REPEATED   = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_FIELDS = 2'd0,
        PH_CHARS  = 2'd1,
        PH_KEY    = 2'd2
    } phase_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic [31:0] run_count;
        logic        dup;
        logic        show_line;
    } out_item_t;

    typedef struct packed {
        logic        fold_case;
        logic [7:0]  fields_to_skip;
        logic [11:0] chars_to_skip;
        logic        only_repeated;
        logic        only_unique;
        logic        all_repeated_mode;
    } cfg_t;

    // One parsed byte handed from the parser to the run tracker.
    typedef struct packed {
        logic              flush;
        logic              key_hit;
        logic              line_end;
        logic [ADDR_W-1:0] idx;
        logic [7:0]        data;
        logic [LEN_W-1:0]  len;
    } parsed_t;

    typedef struct packed {
        logic              we_a;
        logic              we_b;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } key_wr_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold);
        logic [7:0] r;
        r = b;
        if (fold && b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'd32;
        end
        return r;
    endfunction

endpackage

>>> src/adl_ram.sv
// ---------------------------------------------------------------------------
// adl_ram
// Simple dual-port RAM with one write port and a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module adl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the entry being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/adl_key_parser.sv
// ---------------------------------------------------------------------------
// adl_key_parser
// Front stage: skips fields and characters, finds key bytes and line ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module adl_key_parser (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  logic                      in_valid,
    input  adl_pkg::in_item_t         in_item,
    input  adl_pkg::cfg_t             cfg,
    output logic [adl_pkg::ADDR_W-1:0] rd_addr,
    output logic                      p_valid,
    output adl_pkg::parsed_t          p_item
);

    adl_pkg::phase_t             phase_reg, phase_next;
    logic [7:0]                  fields_seen_reg, fields_seen_next;
    logic                        in_blank_reg, in_blank_next;
    logic [11:0]                 chars_seen_reg, chars_seen_next;
    logic [adl_pkg::ADDR_W-1:0]  line_bytes_reg, line_bytes_next;
    logic                        key_ended_reg, key_ended_next;
    logic [adl_pkg::LEN_W-1:0]   len_reg, len_next;
    logic                        p_valid_reg;
    adl_pkg::parsed_t            p_item_reg, p_item_next;

    logic                        accept;
    logic                        blank;

    assign accept  = in_valid && adv;
    assign blank   = (in_item.data_byte == adl_pkg::CHAR_SPACE) ||
                     (in_item.data_byte == adl_pkg::CHAR_TAB);
    assign rd_addr = len_reg[adl_pkg::ADDR_W-1:0];

    always_comb begin
        adl_pkg::phase_t ph;
        logic go;
        logic hit;
        logic ends;
        logic [adl_pkg::ADDR_W-1:0] lb_inc;

        phase_next       = phase_reg;
        fields_seen_next = fields_seen_reg;
        in_blank_next    = in_blank_reg;
        chars_seen_next  = chars_seen_reg;
        line_bytes_next  = line_bytes_reg;
        key_ended_next   = key_ended_reg;
        len_next         = len_reg;
        ph  = phase_reg;
        go  = 1'b0;
        hit = 1'b0;

        if (!key_ended_reg) begin
            if (in_item.data_byte == adl_pkg::CHAR_NUL) begin
                key_ended_next = 1'b1;
            end else begin
                go = 1'b1;
            end
        end
        if (go && ph == adl_pkg::PH_FIELDS) begin
            if (in_blank_reg && blank) begin
                go = 1'b0;
            end else if (fields_seen_reg >= cfg.fields_to_skip) begin
                in_blank_next = 1'b0;
                ph = adl_pkg::PH_CHARS;
            end else begin
                go = 1'b0;
                in_blank_next = blank;
                if (blank) begin
                    fields_seen_next = fields_seen_reg + 8'd1;
                end
            end
        end
        if (go && ph == adl_pkg::PH_CHARS) begin
            if (chars_seen_reg < cfg.chars_to_skip) begin
                chars_seen_next = chars_seen_reg + 12'd1;
                go = 1'b0;
            end else begin
                ph = adl_pkg::PH_KEY;
            end
        end
        if (go && ph == adl_pkg::PH_KEY && !len_reg[adl_pkg::LEN_W-1]) begin
            hit = 1'b1;
            len_next = len_reg + 1'b1;
        end
        phase_next = ph;

        // Lines that fill the buffer without a mark are split here.
        lb_inc = line_bytes_reg + 1'b1;
        line_bytes_next = lb_inc;
        ends = in_item.line_end || (lb_inc >= adl_pkg::ADDR_W'(adl_pkg::LINE_BYTES - 1));

        p_item_next.flush    = in_item.cmd;
        p_item_next.key_hit  = hit && !in_item.cmd;
        p_item_next.line_end = ends && !in_item.cmd;
        p_item_next.idx      = len_reg[adl_pkg::ADDR_W-1:0];
        p_item_next.data     = in_item.data_byte;
        p_item_next.len      = len_next;

        if (in_item.cmd || ends) begin
            phase_next       = adl_pkg::PH_FIELDS;
            fields_seen_next = '0;
            in_blank_next    = 1'b0;
            chars_seen_next  = '0;
            line_bytes_next  = '0;
            key_ended_next   = 1'b0;
            len_next         = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= adl_pkg::PH_FIELDS;
            fields_seen_reg <= '0;
            in_blank_reg    <= 1'b0;
            chars_seen_reg  <= '0;
            line_bytes_reg  <= '0;
            key_ended_reg   <= 1'b0;
            len_reg         <= '0;
            p_valid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg       <= phase_next;
                fields_seen_reg <= fields_seen_next;
                in_blank_reg    <= in_blank_next;
                chars_seen_reg  <= chars_seen_next;
                line_bytes_reg  <= line_bytes_next;
                key_ended_reg   <= key_ended_next;
                len_reg         <= len_next;
            end
            if (adv) begin
                p_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_item_reg <= p_item_next;
        end
    end

    assign p_valid = p_valid_reg;
    assign p_item  = p_item_reg;

endmodule

>>> src/adl_run_tracker.sv
// ---------------------------------------------------------------------------
// adl_run_tracker
// Back stage: compares key bytes with the stored key and counts runs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module adl_run_tracker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              p_valid,
    input  adl_pkg::parsed_t  p_item,
    input  adl_pkg::cfg_t     cfg,
    input  logic [7:0]        rdata_a,
    input  logic [7:0]        rdata_b,
    output adl_pkg::key_wr_t  key_wr,
    output logic              emit,
    output adl_pkg::out_item_t result
);

    logic                            prev_in_b_reg, prev_in_b_next;
    logic [adl_pkg::LEN_W-1:0]       prev_len_reg, prev_len_next;
    logic                            key_differs_reg, key_differs_next;
    logic [adl_pkg::COUNT_BITS-1:0]  run_counter_reg, run_counter_next;
    logic                            have_prev_reg, have_prev_next;

    // Last write, for a read of the same entry in the same cycle.
    logic                            fwd_valid_reg;
    logic                            fwd_store_reg;
    logic [adl_pkg::ADDR_W-1:0]      fwd_addr_reg;
    logic [7:0]                      fwd_data_reg;

    logic       work;
    logic [7:0] prv_byte;
    logic       mismatch, differs, same;
    logic       dup;
    logic [63:0] count_wide;

    assign work = adv && p_valid;

    always_comb begin
        prv_byte = prev_in_b_reg ? rdata_b : rdata_a;
        if (fwd_valid_reg && fwd_store_reg == prev_in_b_reg && fwd_addr_reg == p_item.idx) begin
            prv_byte = fwd_data_reg;
        end
        mismatch = p_item.key_hit &&
                   (({1'b0, p_item.idx} >= prev_len_reg) ||
                    (adl_pkg::fold_byte(prv_byte, cfg.fold_case) !=
                     adl_pkg::fold_byte(p_item.data, cfg.fold_case)));
        differs = key_differs_reg || mismatch;
        same    = have_prev_reg && !differs && (p_item.len == prev_len_reg);
    end

    assign key_wr.we_a = work && !p_item.flush && p_item.key_hit && prev_in_b_reg;
    assign key_wr.we_b = work && !p_item.flush && p_item.key_hit && !prev_in_b_reg;
    assign key_wr.addr = p_item.idx;
    assign key_wr.data = p_item.data;

    always_comb begin
        prev_in_b_next   = prev_in_b_reg;
        prev_len_next    = prev_len_reg;
        key_differs_next = key_differs_reg;
        run_counter_next = run_counter_reg;
        have_prev_next   = have_prev_reg;
        emit             = 1'b0;
        if (work) begin
            if (p_item.flush) begin
                emit             = have_prev_reg;
                prev_in_b_next   = 1'b0;
                prev_len_next    = '0;
                key_differs_next = 1'b0;
                run_counter_next = '0;
                have_prev_next   = 1'b0;
            end else if (p_item.line_end) begin
                key_differs_next = 1'b0;
                if (same) begin
                    if (run_counter_reg != '1) begin
                        run_counter_next = run_counter_reg + 1'b1;
                    end
                end else begin
                    emit             = have_prev_reg;
                    prev_in_b_next   = !prev_in_b_reg;
                    prev_len_next    = p_item.len;
                    run_counter_next = adl_pkg::COUNT_BITS'(1);
                    have_prev_next   = 1'b1;
                end
            end else begin
                key_differs_next = differs;
            end
        end
    end

    always_comb begin
        count_wide = 64'(run_counter_reg);
        dup = count_wide > 64'd1;
        result.run_count    = (count_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : count_wide[31:0];
        result.dup          = dup;
        result.show_line    = !((cfg.only_repeated && !dup) || (cfg.only_unique && dup) ||
                                (cfg.all_repeated_mode && !dup));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_in_b_reg   <= 1'b0;
            prev_len_reg    <= '0;
            key_differs_reg <= 1'b0;
            run_counter_reg <= '0;
            have_prev_reg   <= 1'b0;
            fwd_valid_reg   <= 1'b0;
        end else begin
            prev_in_b_reg   <= prev_in_b_next;
            prev_len_reg    <= prev_len_next;
            key_differs_reg <= key_differs_next;
            run_counter_reg <= run_counter_next;
            have_prev_reg   <= have_prev_next;
            if (adv) begin
                fwd_valid_reg <= key_wr.we_a || key_wr.we_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fwd_store_reg <= !prev_in_b_reg;
            fwd_addr_reg  <= p_item.idx;
            fwd_data_reg  <= p_item.data;
        end
    end

endmodule

>>> src/adjacent_line_dedup_top.sv
// ---------------------------------------------------------------------------
// adjacent_line_dedup_top
// Adjacent duplicate line filter with an APB register port.
// ---------------------------------------------------------------------------
// The block accepts one text byte per clock cycle, or one flush transaction,
// and reports one result transaction each time a run of lines with equal keys
// ends: when a line with a different key completes, or on a flush. The byte
// that ends a run is registered in the parser, and its result then in the
// output register; the input keeps taking one byte per cycle as long as the
// output side takes results. The rate is set by the two key memories, each
// read once and written once per cycle: the key of the current line is
// written into one while the key of the run's first line is read from the
// other, and the roles swap when a new run starts. No clearing pass runs
// after reset; the block is ready as soon as reset is released.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adjacent_line_dedup_top_defines.svh"

module adjacent_line_dedup_top (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  adl_pkg::in_item_t             s_data,

    output logic                          m_valid,
    input  logic                          m_ready,
    output adl_pkg::out_item_t            m_data,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [adl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // Configuration registers; the user must write them only while the stream is idle (not enforced here).
    adl_pkg::cfg_t       cfg_reg;
    adl_pkg::cfg_index_t cfg_sel;
    logic                cfg_wr;

    // The whole pipeline advances together whenever the output register
    // can take a new value: it is empty or its transaction completes now.
    logic                       adv;
    logic [adl_pkg::ADDR_W-1:0] rd_addr;
    logic                       p_valid;
    adl_pkg::parsed_t           p_item;
    logic [7:0]                 rdata_a, rdata_b;
    adl_pkg::key_wr_t           key_wr;
    logic                       emit;
    adl_pkg::out_item_t         result;

    logic                       m_valid_reg;
    adl_pkg::out_item_t         m_data_reg;

    assign pready  = 1'b1;
    assign cfg_sel = adl_pkg::cfg_index_t'(paddr[adl_pkg::CFG_ADDR_W-1:adl_pkg::REG_IDX_LSB]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_sel)
                adl_pkg::REG_FOLD_CASE:      cfg_reg.fold_case         <= pwdata[0];
                adl_pkg::REG_FIELDS_TO_SKIP: cfg_reg.fields_to_skip    <= pwdata[7:0];
                adl_pkg::REG_CHARS_TO_SKIP:  cfg_reg.chars_to_skip     <= pwdata[11:0];
                adl_pkg::REG_ONLY_REPEATED:  cfg_reg.only_repeated     <= pwdata[0];
                adl_pkg::REG_ONLY_UNIQUE:    cfg_reg.only_unique       <= pwdata[0];
                adl_pkg::REG_ALL_REPEATED:   cfg_reg.all_repeated_mode <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            adl_pkg::REG_FOLD_CASE:      prdata = 32'(cfg_reg.fold_case);
            adl_pkg::REG_FIELDS_TO_SKIP: prdata = 32'(cfg_reg.fields_to_skip);
            adl_pkg::REG_CHARS_TO_SKIP:  prdata = 32'(cfg_reg.chars_to_skip);
            adl_pkg::REG_ONLY_REPEATED:  prdata = 32'(cfg_reg.only_repeated);
            adl_pkg::REG_ONLY_UNIQUE:    prdata = 32'(cfg_reg.only_unique);
            adl_pkg::REG_ALL_REPEATED:   prdata = 32'(cfg_reg.all_repeated_mode);
            default:                     prdata = '0;
        endcase
    end

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    adl_key_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_valid),
        .in_item  (s_data),
        .cfg      (cfg_reg),
        .rd_addr  (rd_addr),
        .p_valid  (p_valid),
        .p_item   (p_item)
    );

    // Both stores are read whenever the pipeline advances; the tracker picks the one holding
    // the run's key once it knows whether the previous line started a run.
    adl_ram #(
        .WIDTH (8),
        .DEPTH (adl_pkg::LINE_BYTES)
    ) u_key_store_a (
        .aclk  (aclk),
        .we    (key_wr.we_a),
        .waddr (key_wr.addr),
        .wdata (key_wr.data),
        .re    (adv),
        .raddr (rd_addr),
        .rdata (rdata_a)
    );

    adl_ram #(
        .WIDTH (8),
        .DEPTH (adl_pkg::LINE_BYTES)
    ) u_key_store_b (
        .aclk  (aclk),
        .we    (key_wr.we_b),
        .waddr (key_wr.addr),
        .wdata (key_wr.data),
        .re    (adv),
        .raddr (rd_addr),
        .rdata (rdata_b)
    );

    adl_run_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .p_valid (p_valid),
        .p_item  (p_item),
        .cfg     (cfg_reg),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .key_wr  (key_wr),
        .emit    (emit),
        .result  (result)
    );

    // Output register: a waiting result transaction holds the pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ADL_ASSERT_NOW(a_stall_blocks_input, m_valid && !m_ready, !s_ready, "input taken in stall")
    `ADL_ASSERT_NOW(a_dup_flag, m_valid, m_data.dup == (m_data.run_count > 32'd1), "bad dup flag")
    `ADL_ASSERT_NOW(a_count_nonzero, m_valid, m_data.run_count != 32'd0, "result with empty run")

endmodule
